FILE: hdl/met_pkg.sv
// shared constants, codes and types of the magnetic encoder angle tracker
package met_pkg;

  localparam int ANGLE_BITS     = 14;
  localparam int TURN_BITS      = 16;
  localparam int WORD_BITS      = 16;
  localparam int POS_BITS       = 30;
  localparam int VEL_BITS       = 40;
  localparam int DIFF_BITS      = POS_BITS + 1;
  localparam int SCALE_BITS     = 10;
  localparam int MAG_BITS       = DIFF_BITS + SCALE_BITS;
  localparam int STATUS_BITS    = 2;
  localparam int SCORE_BITS     = 8;
  localparam int CFG_INDEX_BITS = 1;
  localparam int DIV_STEPS      = MAG_BITS;
  localparam int STEP_BITS      = $clog2(DIV_STEPS);
  localparam int HALF_TURN      = 1 << (ANGLE_BITS - 1);

  localparam logic [SCALE_BITS-1:0] VEL_SCALE   = SCALE_BITS'(1000);
  localparam logic [SCORE_BITS:0]   SCORE_STEP  = (SCORE_BITS + 1)'(10);
  localparam logic [SCORE_BITS-1:0] SCORE_LIMIT = SCORE_BITS'(100);
  localparam logic [SCORE_BITS-1:0] SCORE_MAX   = {SCORE_BITS{1'b1}};

  localparam logic [WORD_BITS-1:0] NO_MAGNET_RESET = WORD_BITS'(2);
  localparam logic [WORD_BITS-1:0] PARITY_RESET    = WORD_BITS'(1);

  typedef enum logic [STATUS_BITS-1:0] {
    ST_RUNNING = 2'd0,
    ST_OFFLINE = 2'd1,
    ST_PARITY  = 2'd2
  } sensor_status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NO_MAGNET_MASK = 1'b0,
    REG_PARITY_MASK    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/met_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module met_div (
  input  logic                           clk,
  input  logic                           rst,
  input  met_pkg::div_ctl_t              ctl,
  input  logic [met_pkg::MAG_BITS-1:0]   dividend,
  input  logic [met_pkg::WORD_BITS-1:0]  divisor,
  output met_pkg::div_stat_t             stat,
  output logic [met_pkg::MAG_BITS-1:0]   quotient
);
  import met_pkg::*;

  logic                 busy;
  logic                 done;
  logic [STEP_BITS-1:0] step;
  logic [WORD_BITS-1:0] divisor_q;
  logic [WORD_BITS-1:0] rem;
  logic [MAG_BITS-1:0]  dvd;
  logic [WORD_BITS:0]   trial;

  // shift in the next dividend bit and try to take the divisor out
  assign trial = {rem, dvd[MAG_BITS-1]} - {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd       <= dividend;
      rem       <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      if (!trial[WORD_BITS]) begin
        rem <= trial[WORD_BITS-1:0];
        dvd <= {dvd[MAG_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[WORD_BITS-2:0], dvd[MAG_BITS-1]};
        dvd <= {dvd[MAG_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

FILE: hdl/magnetic_encoder_angle_tracker.sv
// multi-turn angle, position and velocity tracker for a 14-bit magnetic encoder
//
//   channel  signals                                         direction
//   in       in_valid, in_stall, high_word, low_word,        request in
//            time_delta_ms
//   out      out_valid, out_stall, angle_counts,             request out
//            position_counts, velocity_cps, sensor_status,
//            parity_ok
//   cfg      cfg_write, cfg_index, cfg_data                  write only
//
// a request with a nonzero time gap and the magnet present is taken in,
// scaled by 1000 as the divider starts, divided in the serial divider
// (41 quotient bits, then a done pulse) and handed on to the output
// register; otherwise it goes straight from intake to the output register
// the output register lets the next request in while a result waits
// rst is synchronous, clears all tracking state and restores the masks
// in_stall is high while a request is in work
module magnetic_encoder_angle_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [met_pkg::WORD_BITS-1:0]       high_word,
  input  logic [met_pkg::WORD_BITS-1:0]       low_word,
  input  logic [met_pkg::WORD_BITS-1:0]       time_delta_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [met_pkg::ANGLE_BITS-1:0]      angle_counts,
  output logic signed [met_pkg::POS_BITS-1:0] position_counts,
  output logic signed [met_pkg::VEL_BITS-1:0] velocity_cps,
  output logic [met_pkg::STATUS_BITS-1:0]     sensor_status,
  output logic                                parity_ok,
  input  logic                                cfg_write,
  input  logic [met_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [met_pkg::WORD_BITS-1:0]       cfg_data
);
  import met_pkg::*;

  localparam logic [MAG_BITS-1:0] VEL_POS_LIMIT = MAG_BITS'((64'd1 << (VEL_BITS - 1)) - 1);
  localparam logic [MAG_BITS-1:0] VEL_NEG_LIMIT = MAG_BITS'(64'd1 << (VEL_BITS - 1));
  localparam logic [VEL_BITS-1:0] VEL_MAX = {1'b0, {(VEL_BITS - 1){1'b1}}};
  localparam logic [VEL_BITS-1:0] VEL_MIN = {1'b1, {(VEL_BITS - 1){1'b0}}};

  fsm_state_t state, state_next;

  logic [WORD_BITS-1:0]   no_magnet_mask;
  logic [WORD_BITS-1:0]   parity_mask;
  logic [TURN_BITS-1:0]   turn_count;
  logic [ANGLE_BITS-1:0]  previous_angle;
  logic [POS_BITS-1:0]    previous_position;
  logic [VEL_BITS-1:0]    held_velocity;
  logic [SCORE_BITS-1:0]  error_score;
  sensor_status_t         status_reg;

  logic [ANGLE_BITS-1:0]  res_angle;
  logic [POS_BITS-1:0]    res_pos;
  logic                   res_parity;
  logic [DIFF_BITS-1:0]   diff_mag;
  logic                   vel_neg;
  logic [WORD_BITS-1:0]   dt_q;

  logic                   accept;
  logic                   out_load;
  div_ctl_t               div_ctl;
  div_stat_t              div_stat;
  logic [MAG_BITS-1:0]    div_quot;
  logic [MAG_BITS-1:0]    scaled;
  logic [VEL_BITS-1:0]    vel_sat;

  logic [ANGLE_BITS-1:0]      angle_w;
  logic signed [ANGLE_BITS:0] delta;
  logic [TURN_BITS-1:0]       turn_next;
  logic [POS_BITS-1:0]        pos_w;
  logic [DIFF_BITS-1:0]       pos_diff;
  logic                       no_magnet;
  logic                       sensor_par;
  logic                       par_ok;
  logic [SCORE_BITS:0]        score_sum;
  logic [SCORE_BITS-1:0]      score_upd;
  sensor_status_t             status_upd;

  // sample decode, turn tracking, magnet check, parity scoring and status
  always_comb begin
    angle_w = {high_word[7:0], low_word[7:2]};
    delta   = $signed({1'b0, angle_w}) - $signed({1'b0, previous_angle});
    if (delta < -HALF_TURN) begin
      turn_next = turn_count + 1'b1;
    end else if (delta > HALF_TURN) begin
      turn_next = turn_count - 1'b1;
    end else begin
      turn_next = turn_count;
    end
    pos_w    = POS_BITS'($signed({turn_next, angle_w}));
    pos_diff = {pos_w[POS_BITS-1], pos_w}
             - {previous_position[POS_BITS-1], previous_position};

    no_magnet  = |(low_word & no_magnet_mask);
    sensor_par = |(low_word & parity_mask);
    par_ok     = (^angle_w) == sensor_par;

    score_sum = {1'b0, error_score} + SCORE_STEP;
    if (!par_ok) begin
      score_upd = score_sum[SCORE_BITS] ? SCORE_MAX : score_sum[SCORE_BITS-1:0];
    end else if (error_score != '0) begin
      score_upd = error_score - 1'b1;
    end else begin
      score_upd = error_score;
    end

    if (no_magnet) begin
      status_upd = ST_OFFLINE;
    end else if (score_upd > SCORE_LIMIT) begin
      status_upd = ST_PARITY;
    end else begin
      status_upd = ST_RUNNING;
    end
  end

  // scale by 1000 right before the divider takes it: 1024 - 32 + 8
  assign scaled = (MAG_BITS'(diff_mag) << 10) - (MAG_BITS'(diff_mag) << 5)
                + (MAG_BITS'(diff_mag) << 3);

  always_comb begin
    if (vel_neg) begin
      vel_sat = (div_quot > VEL_NEG_LIMIT) ? VEL_MIN : -div_quot[VEL_BITS-1:0];
    end else begin
      vel_sat = (div_quot > VEL_POS_LIMIT) ? VEL_MAX : div_quot[VEL_BITS-1:0];
    end
  end

  met_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (scaled),
    .divisor  (dt_q),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (no_magnet || time_delta_ms == '0) ? S_DONE : S_MUL;
        end
      end
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    div_ctl.start = (state == S_MUL);
    out_load      = (state == S_DONE) && (!out_valid || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      no_magnet_mask <= NO_MAGNET_RESET;
      parity_mask    <= PARITY_RESET;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_NO_MAGNET_MASK: no_magnet_mask <= cfg_data;
          REG_PARITY_MASK:    parity_mask    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_count        <= '0;
      previous_angle    <= '0;
      previous_position <= '0;
      held_velocity     <= '0;
      error_score       <= '0;
      status_reg        <= ST_RUNNING;
    end else begin
      if (accept) begin
        turn_count <= turn_next;
        status_reg <= status_upd;
        if (no_magnet) begin
          previous_angle    <= '0;
          previous_position <= '0;
          held_velocity     <= '0;
        end else begin
          previous_angle    <= angle_w;
          previous_position <= pos_w;
          error_score       <= score_upd;
        end
      end
      if (state == S_DIV && div_stat.done) begin
        held_velocity <= vel_sat;
      end
    end
  end

  // per-request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_angle  <= no_magnet ? '0 : angle_w;
      res_pos    <= no_magnet ? '0 : pos_w;
      res_parity <= par_ok;
      vel_neg    <= pos_diff[DIFF_BITS-1];
      diff_mag   <= pos_diff[DIFF_BITS-1] ? -pos_diff : pos_diff;
      dt_q       <= time_delta_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      angle_counts    <= res_angle;
      position_counts <= $signed(res_pos);
      velocity_cps    <= $signed(held_velocity);
      sensor_status   <= status_reg;
      parity_ok       <= res_parity;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request taken while idle did not start work");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> out_valid)
    else $error("finished result not moved to the output register");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider still busy while waiting for a request");

endmodule
